// File: design/gwo_pkg.sv
// Shared constants, types and the quarter-wave sine table for the gated oscillator.
package gwo_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int TAB_N      = 1 << SINE_TABLE_BITS;
  localparam int TAB_DIV    = 2 * TAB_N;
  localparam int AMP_W      = SAMPLE_BITS - 1;
  localparam int AMP_MAX    = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int QUAD_BITS  = SINE_TABLE_BITS + 2;
  localparam int PHASE_XW   = PHASE_BITS + SAMPLE_BITS;

  localparam int WAVE_W     = 2;
  localparam int STEP_W     = 32;
  localparam int VOL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8;

  localparam logic [STEP_W-1:0] STEP_RESET = 32'd9842895;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 16'd1638;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF    = 64'd1 << 29;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 2'd2;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2
  } wave_e;

  // Per-sample phase taps carried from the input stage to the scaler
  typedef struct packed {
    logic                   sine_neg;
    logic                   square_neg;
    logic [SAMPLE_BITS-1:0] saw;
    logic                   enabled;
  } tap_t;

  typedef logic [AMP_W-1:0] sine_tab_t [TAB_N];

  // Quarter-wave table: Taylor series to x^11 in Q2.30, sampled at bin centers.
  function automatic sine_tab_t sine_tab_f();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i < TAB_N; i++) begin
      x  = (HALF_PI_Q30 * 64'(2 * i + 1) + 64'(TAB_N)) / 64'(TAB_DIV);
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'(AMP_MAX) + Q30_HALF) >> 30;
      if (v > 64'(AMP_MAX)) begin
        v = 64'(AMP_MAX);
      end
      tab[i] = v[AMP_W-1:0];
    end
    return tab;
  endfunction

endpackage

// File: design/gwo_sine_rom.sv
// Quarter-wave sine ROM with registered read data.
module gwo_sine_rom
  import gwo_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [SINE_TABLE_BITS-1:0] addr_i,
  output logic [AMP_W-1:0]           data_o
);

  localparam sine_tab_t ROM = sine_tab_f();

  logic [AMP_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: design/gwo_phase_ctrl.sv
// Phase accumulator with start/stop gating applied on phase wrap.
module gwo_phase_ctrl
  import gwo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  start_i,
  input  logic                  stop_i,
  input  logic [STEP_W-1:0]     phase_step_i,
  output logic [PHASE_BITS-1:0] phase_o,
  output logic                  enabled_o
);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic                  enabled_q, enabled_d;
  logic                  start_pend_q, start_pend_d;
  logic                  stop_pend_q, stop_pend_d;
  logic [PHASE_BITS:0]   phase_sum;
  logic                  start_p, stop_p;

  assign phase_sum = {1'b0, phase_q} + {1'b0, PHASE_BITS'(phase_step_i)};
  assign start_p   = start_pend_q | start_i;
  assign stop_p    = stop_pend_q | stop_i;

  always_comb begin
    phase_d      = phase_q;
    enabled_d    = enabled_q;
    start_pend_d = start_pend_q;
    stop_pend_d  = stop_pend_q;
    if (accept_i) begin
      phase_d      = phase_sum[PHASE_BITS-1:0];
      start_pend_d = start_p;
      stop_pend_d  = stop_p;
      // on wrap: start wins and leaves any stop pending
      if (phase_sum[PHASE_BITS]) begin
        priority if (start_p) begin
          start_pend_d = 1'b0;
          enabled_d    = 1'b1;
        end else if (stop_p) begin
          stop_pend_d = 1'b0;
          enabled_d   = 1'b0;
        end else begin
          // nothing pending: hold the gate
          enabled_d = enabled_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= '0;
      enabled_q    <= 1'b0;
      start_pend_q <= 1'b0;
      stop_pend_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      enabled_q    <= enabled_d;
      start_pend_q <= start_pend_d;
      stop_pend_q  <= stop_pend_d;
    end
  end

  assign phase_o   = phase_q;
  assign enabled_o = enabled_q;

`ifndef SYNTHESIS
  a_gate_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(enabled_q) && $stable(phase_q))
    else $error("gating state moved without a transaction");

  a_unmute_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(enabled_q) |-> $past(start_pend_q || start_i))
    else $error("unmuted without a pending start");

  a_stop_mutes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(stop_pend_q) |-> !enabled_q && !start_pend_q)
    else $error("stop consumed but output not muted");
`endif

endmodule

// File: design/gwo_wave_scale.sv
// Waveform select, volume multiply, rounding and saturation; the sample is muted while the tap is disabled.
module gwo_wave_scale
  import gwo_pkg::*;
(
  input  tap_t                          tap_i,
  input  logic [AMP_W-1:0]              sine_i,
  input  wave_e                         waveform_i,
  input  logic [VOL_W-1:0]              volume_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int PROD_W = SAMPLE_BITS + VOL_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(AMP_MAX);
  localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(AMP_MAX) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) <<< (VOL_W - 1);

  logic signed [SAMPLE_BITS-1:0] wave;
  logic signed [SAMPLE_BITS-1:0] sine_pos;
  logic signed [PROD_W-1:0]      wave_x;
  logic signed [PROD_W-1:0]      vol_x;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       q;

  assign sine_pos = {1'b0, sine_i};

  always_comb begin
    unique case (waveform_i)
      WAVE_SINE:   wave = tap_i.sine_neg ? -sine_pos : sine_pos;
      WAVE_SQUARE: wave = tap_i.square_neg ? -SAMPLE_BITS'(AMP_MAX) : SAMPLE_BITS'(AMP_MAX);
      WAVE_SAW:    wave = tap_i.saw;
      default:     wave = '0;
    endcase
  end

  assign wave_x = PROD_W'(wave);
  assign vol_x  = PROD_W'({1'b0, volume_i});
  assign prod   = wave_x * vol_x;
  assign sum    = SUM_W'(prod) + RND;
  // floor division by 2^16 for both signs
  assign q      = sum >>> VOL_W;

  always_comb begin
    priority if (!tap_i.enabled) begin
      sample_o = '0;
    end else if (q > Q_MAX) begin
      sample_o = SAMPLE_BITS'(Q_MAX);
    end else if (q < Q_MIN) begin
      sample_o = SAMPLE_BITS'(Q_MIN);
    end else begin
      sample_o = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

// File: design/gated_waveform_oscillator.sv
// Gated sine/square/sawtooth oscillator top level with stream ports and config port.
//
//   port group   dir  payload                                      transfer
//   s_axis_*     in   tdata[0] start_request, tdata[1] stop_request tvalid & tready
//   m_axis_*     out  tdata[15:0] sample, tdata[16] sound_on       tvalid & tready
//   cfg_*        in   index 0 waveform, 1 phase_step, 2 volume      cfg_we_i
//
// One transaction per clock sustained while the output is not stalled; an accepted input is
// registered in the ROM read and tap stage, then multiplied, saturated and registered into
// the output register, which drives m_axis_tvalid.
// Phase and gating state update in the cycle the input transaction is taken.
// A stalled output holds the output register, then the ROM stage, then s_axis_tready drops.
// Reset clears phase, gating state, valid flags and restores register defaults.
module gated_waveform_oscillator
  import gwo_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] start_request, [1] stop_request
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [SAMPLE_BITS-1:0] sample, next sound_on
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  wave_e                  waveform_q;
  logic [STEP_W-1:0]      phase_step_q;
  logic [VOL_W-1:0]       volume_q;

  logic                   accept;
  logic                   adv_out;
  logic                   tap_valid_q;
  logic                   out_valid_q;
  tap_t                   tap_q, tap_d;
  logic [PHASE_BITS-1:0]  phase;
  logic                   enabled;
  logic [PHASE_XW-1:0]    phase_ext;
  logic [QUAD_BITS-1:0]   phase_top;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic [AMP_W-1:0]       sine_val;
  logic signed [SAMPLE_BITS-1:0] sample_d, sample_q;
  logic                   sound_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q   <= WAVE_SINE;
      phase_step_q <= STEP_RESET;
      volume_q     <= VOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WAVEFORM:   waveform_q   <= wave_e'(cfg_data_i[WAVE_W-1:0]);
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_VOLUME:     volume_q     <= cfg_data_i[VOL_W-1:0];
        default:        ;
      endcase
    end
  end

  assign adv_out       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !tap_valid_q || adv_out;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gwo_phase_ctrl u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .start_i      (s_axis_tdata[0]),
    .stop_i       (s_axis_tdata[1]),
    .phase_step_i (phase_step_q),
    .phase_o      (phase),
    .enabled_o    (enabled)
  );

  // zero-fill below the accumulator so narrow phases still give full-width taps
  assign phase_ext = {phase, SAMPLE_BITS'(0)};
  assign phase_top = phase_ext[PHASE_XW-1 -: QUAD_BITS];
  assign rom_addr  = phase_top[QUAD_BITS-2] ? ~phase_top[SINE_TABLE_BITS-1:0]
                                            : phase_top[SINE_TABLE_BITS-1:0];

  always_comb begin
    tap_d.sine_neg   = phase_top[QUAD_BITS-1];
    tap_d.square_neg = phase_ext[PHASE_XW-1];
    tap_d.saw        = {~phase_ext[PHASE_XW-1], phase_ext[PHASE_XW-2 -: SAMPLE_BITS-1]};
    tap_d.enabled    = enabled;
  end

  gwo_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (accept),
    .addr_i (rom_addr),
    .data_o (sine_val)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tap_q <= tap_d;
    end
  end

  gwo_wave_scale u_scale (
    .tap_i      (tap_q),
    .sine_i     (sine_val),
    .waveform_i (waveform_q),
    .volume_i   (volume_q),
    .sample_o   (sample_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tap_valid_q <= 1'b1;
      end else if (adv_out) begin
        tap_valid_q <= 1'b0;
      end
      if (adv_out) begin
        out_valid_q <= tap_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && tap_valid_q) begin
      sample_q   <= sample_d;
      sound_on_q <= tap_q.enabled;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({sound_on_q, sample_q});

`ifndef SYNTHESIS
  a_muted_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !sound_on_q |-> sample_q == '0)
    else $error("nonzero sample while muted");

  a_no_drop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_valid_q && !adv_out |=> tap_valid_q && $stable(tap_q))
    else $error("ROM stage lost a sample during output stall");
`endif

endmodule

// File: dv/gated_waveform_oscillator_test.sv
// Self-checking testbench for the gated waveform oscillator: directed plan, then random phases.
module gated_waveform_oscillator_test import gwo_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_TICKS  = 750;
  localparam int PLAN_ROWS     = 36;
  localparam int REPORT_MAX    = 10;

  localparam logic [WAVE_W-1:0] WAVE_UNUSED = 2'd3;
  localparam logic [63:0] QUARTER_TURN_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30           = 64'd1 << 30;
  localparam int LEVEL_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int LEVEL_MIN = -(1 << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   sound_on;
  } tick_out_t;

  typedef struct packed {
    logic      pinned;
    tick_out_t value;
  } pin_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   start;
    logic                   stop;
    logic                   pinned;
    logic [SAMPLE_BITS-1:0] exp_sample;
    logic                   exp_on;
  } plan_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // Oscillator mirror: registers and gating state
  logic [WAVE_W-1:0]     wave_sel    = WAVE_SINE;
  logic [STEP_W-1:0]     step_reg    = 32'd9842895;
  logic [VOL_W-1:0]      gain        = 16'd1638;
  logic [PHASE_BITS-1:0] phase_acc   = '0;
  logic                  gate_on     = 1'b0;
  logic                  start_armed = 1'b0;
  logic                  stop_armed  = 1'b0;
  logic [AMP_W-1:0]      sine_rom [TAB_N];

  tick_out_t due_samples [$];
  pin_t      pins [$];
  int        faults      = 0;
  int        idle_cycles = 0;

  rx_mode_e  rx_mode = RX_OPEN;
  int        rx_left = 0;
  int        rx_tick = 0;

  plan_row_t plan [PLAN_ROWS];

  gated_waveform_oscillator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Quarter-wave sine at bin centers, Taylor series to x^11 in Q2.30
  function automatic void build_sine_rom();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i < TAB_N; i++) begin
      x  = (QUARTER_TURN_Q30 * 64'(2 * i + 1) + 64'(TAB_N)) / 64'(2 * TAB_N);
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'(LEVEL_MAX) + (64'd1 << 29)) >> 30;
      if (v > 64'(LEVEL_MAX)) begin
        v = 64'(LEVEL_MAX);
      end
      sine_rom[i] = v[AMP_W-1:0];
    end
  endfunction

  function automatic int wave_level();
    logic [SINE_TABLE_BITS+1:0] top;
    logic [SINE_TABLE_BITS-1:0] idx;
    int                         mag;
    case (wave_sel)
      WAVE_SINE: begin
        top = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS + 2];
        idx = top[SINE_TABLE_BITS-1:0];
        // odd quadrants run the table backwards, the lower half-turn is negated
        if (top[SINE_TABLE_BITS]) begin
          idx = ~idx;
        end
        mag = int'(sine_rom[idx]);
        return top[SINE_TABLE_BITS+1] ? -mag : mag;
      end
      WAVE_SQUARE: return phase_acc[PHASE_BITS-1] ? -LEVEL_MAX : LEVEL_MAX;
      WAVE_SAW:    return int'(phase_acc[PHASE_BITS-1 -: SAMPLE_BITS]) + LEVEL_MIN;
      default:     return 0;
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] apply_gain(int level);
    longint acc;
    acc = longint'(level) * longint'({1'b0, gain}) + 64'sd32768;
    acc = acc >>> 16;
    if (acc > LEVEL_MAX) begin
      acc = LEVEL_MAX;
    end else if (acc < LEVEL_MIN) begin
      acc = LEVEL_MIN;
    end
    return acc[SAMPLE_BITS-1:0];
  endfunction

  // One sample tick: arm requests, emit, advance phase, gate on a carry
  function automatic tick_out_t next_sample(logic start, logic stop);
    tick_out_t             r;
    logic [PHASE_BITS:0]   sum;
    if (start) begin
      start_armed = 1'b1;
    end
    if (stop) begin
      stop_armed = 1'b1;
    end
    r.sound_on = gate_on;
    r.sample   = gate_on ? apply_gain(wave_level()) : '0;
    sum = {1'b0, phase_acc} + {1'b0, step_reg[PHASE_BITS-1:0]};
    if (sum[PHASE_BITS]) begin
      // start wins; a stop stays armed for a later wrap
      if (start_armed) begin
        start_armed = 1'b0;
        gate_on     = 1'b1;
      end else if (stop_armed) begin
        stop_armed = 1'b0;
        gate_on    = 1'b0;
      end
    end
    phase_acc = sum[PHASE_BITS-1:0];
    return r;
  endfunction

  function automatic void log_fault(string msg);
    if (faults < REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    faults++;
  endfunction

  always @(posedge clk_i) begin
    tick_out_t want;
    tick_out_t got;
    pin_t      pin;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WAVEFORM:   wave_sel = cfg_data_i[WAVE_W-1:0];
          CFG_PHASE_STEP: step_reg = cfg_data_i[STEP_W-1:0];
          CFG_VOLUME:     gain     = cfg_data_i[VOL_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = next_sample(s_axis_tdata[0], s_axis_tdata[1]);
        pin  = pins.pop_front();
        if (pin.pinned) begin
          want = pin.value;
        end
        due_samples.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.sample   = m_axis_tdata[SAMPLE_BITS-1:0];
        got.sound_on = m_axis_tdata[SAMPLE_BITS];
        if (due_samples.size() == 0) begin
          log_fault($sformatf("sample %0d with nothing expected", $signed(got.sample)));
        end else begin
          want = due_samples.pop_front();
          if (got.sample !== want.sample) begin
            log_fault($sformatf("sample expected %0d got %0d",
                                $signed(want.sample), $signed(got.sample)));
          end
          if (got.sound_on !== want.sound_on) begin
            log_fault($sformatf("sound_on expected %0b got %0b",
                                want.sound_on, got.sound_on));
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("** gated_waveform_oscillator: FAILED **");
          $finish;
        end
      end
    end
  end

  // Receiver: switch between stall styles every so often
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_COIN:    m_axis_tready <= 1'($urandom);
      RX_PATTERN: m_axis_tready <= (rx_tick % 5) < 2;
      default:    m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic push_tick(logic start, logic stop, pin_t pin);
    @(negedge clk_i);
    pins.push_back(pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 2){1'b0}}, stop, start};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic hold_input(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {{(IN_TDATA_W - 2){1'b0}}, 2'($urandom)};
    end
  endtask

  // Drop valid, drain every outstanding sample, then let the pipeline go quiet
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int   sent;
    int   run_len;
    int   start_pct;
    int   stop_pct;
    int   burst_left;
    bit   gappy;
    logic [STEP_W-1:0] step_pick;
    logic [VOL_W-1:0]  vol_pick;
    logic [WAVE_W-1:0] wave_pick;
    pin_t pin;

    plan = '{
      // muted after reset: both requests arm, output stays silent
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b1, 1'b1, 1'b1, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b1, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_PHASE_STEP, 32'h8000_0000,       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_WAVEFORM,   32'(WAVE_SQUARE),    1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_VOLUME,     32'h0000_FFFF,       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      // start wins the first wrap, the stop still armed mutes at the next
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      // repeated requests collapse into one
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b1, 1'b1, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b1, 1'b1, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_VOLUME,     32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_WAVEFORM,   32'(WAVE_SAW),       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_PHASE_STEP, 32'hFFFF_FFFF,       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_VOLUME,     32'h0000_FFFF,       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      // wraps every tick: the sawtooth walks down one step at a time
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_WAVEFORM,   32'(WAVE_SINE),      1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_CFG,  CFG_PHASE_STEP, 32'h3FF0_0001,       1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      // unused waveform code: silent sample, gate still reported
      '{ROW_CFG,  CFG_WAVEFORM,   32'(WAVE_UNUSED),    1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      // zero step never wraps, so an armed stop is never applied
      '{ROW_CFG,  CFG_PHASE_STEP, 32'd0,               1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b1, 1'b0, 16'd0, 1'b0},
      '{ROW_TICK, CFG_WAVEFORM,   32'd0,               1'b0, 1'b1, 1'b0, 16'd0, 1'b0}
    };

    build_sine_rom();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_block();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        pin.pinned         = plan[i].pinned;
        pin.value.sample   = plan[i].exp_sample;
        pin.value.sound_on = plan[i].exp_on;
        push_tick(plan[i].start, plan[i].stop, pin);
      end
    end

    sent       = 0;
    burst_left = 0;
    pin        = '0;
    while (sent < RANDOM_TICKS) begin
      settle_block();
      wave_pick = ($urandom_range(0, 9) == 0) ? WAVE_UNUSED : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 7))
        0:       step_pick = 32'h8000_0000;
        1:       step_pick = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        2:       step_pick = $urandom;
        default: step_pick = $urandom_range(32'h0400_0000, 32'h8000_0000);
      endcase
      case ($urandom_range(0, 5))
        0:       vol_pick = 16'hFFFF;
        1:       vol_pick = 16'd0;
        default: vol_pick = 16'($urandom);
      endcase
      cfg_write(CFG_VOLUME, 32'(vol_pick));
      cfg_write(CFG_WAVEFORM, 32'(wave_pick));
      cfg_write(CFG_PHASE_STEP, step_pick);

      run_len   = $urandom_range(30, 90);
      start_pct = $urandom_range(2, 40);
      stop_pct  = $urandom_range(2, 40);
      gappy     = $urandom_range(0, 2) != 0;
      for (int k = 0; k < run_len; k++) begin
        if (gappy && burst_left == 0) begin
          hold_input($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
        push_tick($urandom_range(0, 99) < start_pct, $urandom_range(0, 99) < stop_pct, pin);
        if (burst_left > 0) begin
          burst_left--;
        end
      end
      sent += run_len;
    end

    settle_block();
    if (faults == 0) begin
      $display("** gated_waveform_oscillator: PASSED **");
    end else begin
      $display("** gated_waveform_oscillator: FAILED **");
    end
    $finish;
  end

endmodule
